>>> rtl/pat_pkg.sv
// Shared types and codes for the positional array table.
// Used by pat_cell, pat_first_match and positional_array_table; no dependencies.
package pat_pkg;

  localparam int PAT_DEPTH = 16;
  localparam int WORD_W    = 32;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_UPDATE = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // Broadcast to every cell; en is set only for a legal write request.
  typedef struct packed {
    logic               en;
    op_t                op;
    logic [WORD_W-1:0]  value;
  } cell_cmd_t;

endpackage

>>> rtl/pat_cell.sv
// One slot of the table: holds an entry, shifts with its neighbors, compares.
// Depends on pat_pkg.
module pat_cell
  import pat_pkg::*;
#(
  parameter int DEPTH    = PAT_DEPTH,
  parameter int CELL_IDX = 0
) (
  input  logic                        clk,
  input  cell_cmd_t                   cmd,
  input  logic [$clog2(DEPTH)-1:0]    idx,
  input  logic [$clog2(DEPTH+1)-1:0]  count,
  input  logic [WORD_W-1:0]           left_entry,
  input  logic [WORD_W-1:0]           right_entry,
  output logic [WORD_W-1:0]           entry,
  output logic                        match
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);
  localparam logic [CW-1:0] MY_POS = CW'(CELL_IDX);

  logic [WORD_W-1:0] entry_r;
  logic [WORD_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.en) begin
      case (cmd.op)
        OP_INSERT: begin
          if (MY_IDX > idx) begin
            entry_nxt = left_entry;
          end else if (MY_IDX == idx) begin
            entry_nxt = cmd.value;
          end
        end
        OP_UPDATE: begin
          if (MY_IDX == idx) begin
            entry_nxt = cmd.value;
          end
        end
        OP_DELETE: begin
          if (MY_IDX >= idx) begin
            entry_nxt = right_entry;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  // only slots below the count take part in a search
  assign match = (entry_r == cmd.value) && (MY_POS < count);

endmodule

>>> rtl/pat_first_match.sv
// Priority encoder: lowest slot whose match bit is set.
// Depends on pat_pkg.
module pat_first_match
  import pat_pkg::*;
#(
  parameter int DEPTH = PAT_DEPTH
) (
  input  logic [DEPTH-1:0]          match_vec,
  output logic                      hit,
  output logic [$clog2(DEPTH)-1:0]  first_idx
);

  localparam int IW = $clog2(DEPTH);

  always_comb begin
    first_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        first_idx = IW'(i);
      end
    end
  end

  assign hit = |match_vec;

endmodule

>>> rtl/positional_array_table.sv
// Top level of the positional array table: a row of pat_cell slots, the count,
// a compare stage and an output register. Depends on pat_pkg, pat_cell, pat_first_match.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in_     | request   | in_valid / in_stall    | in_func, in_position, in_value
//  out_    | result    | out_valid / out_stall  | out_status, out_found_index,
//          |           |                        | out_entry_count
//
// One request per cycle sustained while out_stall is low. A request updates the
// cells and the count at its accept edge; the match vector is registered, then
// encoded into the output register.
// rst_n clears the count and the valid flags; slot contents are not reset.
// out_stall holds the output register and backs up into in_stall once the
// compare stage is also full.
module positional_array_table
  import pat_pkg::*;
#(
  parameter int DEPTH = PAT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_func,
  input  logic [$clog2(DEPTH+1)-1:0]  in_position,
  input  logic signed [WORD_W-1:0]    in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [$clog2(DEPTH)-1:0]    out_found_index,
  output logic [$clog2(DEPTH+1)-1:0]  out_entry_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [CW-1:0] count_r, count_nxt;

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_search_r;
  status_t          s1_status_r;
  logic [CW-1:0]    s1_count_r;
  logic [DEPTH-1:0] s1_match_r;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r;
  logic [IW-1:0]    out_index_r;
  logic [CW-1:0]    out_count_r;

  logic       adv, acc;
  op_t        op;
  status_t    status;
  logic       legal_wr;
  logic [CW:0] pos_ext, cnt_ext;
  logic [IW-1:0] idx;
  cell_cmd_t  cmd;

  logic [WORD_W-1:0] cell_entry [DEPTH];
  logic [DEPTH-1:0]  match_vec;

  logic          enc_hit;
  logic [IW-1:0] enc_idx;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign acc      = in_valid && !in_stall;

  assign op      = op_t'(in_func);
  assign pos_ext = {1'b0, in_position};
  assign cnt_ext = {1'b0, count_r};
  // legal positions never exceed DEPTH, so pos-1 fits the slot index
  assign idx     = IW'(in_position - CW'(1));

  always_comb begin
    status    = ST_OK;
    count_nxt = count_r;
    case (op)
      OP_SEARCH: status = ST_OK;
      OP_INSERT: begin
        if (count_r == FULL_CNT) begin
          status = ST_FULL;
        end else if (in_position == '0 || pos_ext > cnt_ext + (CW+1)'(1)) begin
          status = ST_RANGE;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      OP_UPDATE: begin
        if (in_position == '0 || in_position > count_r) begin
          status = ST_RANGE;
        end
      end
      OP_DELETE: begin
        if (in_position == '0 || in_position > count_r) begin
          status = ST_RANGE;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      default: status = ST_OK;
    endcase
  end

  assign legal_wr  = acc && (op != OP_SEARCH) && (status == ST_OK);
  assign cmd.en    = legal_wr;
  assign cmd.op    = op;
  assign cmd.value = in_value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_entry, right_entry;
    if (i == 0) begin : g_first
      assign left_entry = '0;
    end else begin : g_left
      assign left_entry = cell_entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_right
      assign right_entry = cell_entry[i+1];
    end
    pat_cell #(
      .DEPTH    (DEPTH),
      .CELL_IDX (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .idx         (idx),
      .count       (count_r),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .match       (match_vec[i])
    );
  end

  pat_first_match #(
    .DEPTH (DEPTH)
  ) u_first (
    .match_vec (s1_match_r),
    .hit       (enc_hit),
    .first_idx (enc_idx)
  );

  assign s1_valid_nxt  = acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r <= count_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_search_r <= (op == OP_SEARCH);
      s1_status_r <= status;
      s1_count_r  <= count_nxt;
      s1_match_r  <= match_vec;
    end
    if (adv && s1_valid_r) begin
      out_count_r <= s1_count_r;
      if (s1_search_r) begin
        out_status_r <= enc_hit ? ST_OK : ST_MISS;
        out_index_r  <= enc_hit ? enc_idx : '0;
      end else begin
        out_status_r <= s1_status_r;
        out_index_r  <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_index_r;
  assign out_entry_count = out_count_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("count exceeds depth");

  a_full_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op == OP_INSERT && count_r == FULL_CNT) |=> (count_r == FULL_CNT))
    else $error("refused insert changed the count");

  a_index_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_index_r != '0) |-> (out_status_r == ST_OK))
    else $error("nonzero index without ok status");

  a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (out_count_r == FULL_CNT))
    else $error("full status with a count below depth");

endmodule
